### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/lrrb_pkg.sv
`default_nettype none
package lrrb_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int LEN_W     = 7;
  localparam int REC_W     = 7;
  localparam int SIZE_W    = 16;

  localparam logic [REC_W-1:0] REC_MAX = {REC_W{1'b1}};
  localparam logic [7:0]       NEWLINE = 8'h0A;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic rx_write;
    logic rd_start;
    logic load_refused;
    logic load_empty;
    logic load_byte;
    logic dec_rec;
  } lrrb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic refuse;
    logic empty;
    logic byte_last;
    logic out_free;
  } lrrb_sts_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] n;
    n = (i == IDX_W'(BUF_DEPTH - 1)) ? '0 : i + 1'b1;
    return n;
  endfunction

endpackage
`default_nettype wire

### rtl/lrrb_ctrl.sv
`default_nettype none
module lrrb_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  input  wire                       in_opcode,
  output logic                      in_stall,
  input  wire lrrb_pkg::lrrb_sts_t  sts,
  output lrrb_pkg::lrrb_cmd_t       cmd
);
  import lrrb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_DATA
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_RX) begin
            cmd.rx_write = 1'b1;
          end else begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (sts.refuse) begin
          if (sts.out_free) begin
            cmd.load_refused = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else if (sts.empty) begin
          if (sts.out_free) begin
            cmd.load_empty = 1'b1;
            cmd.dec_rec    = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.load_byte = 1'b1;
          if (sts.byte_last) begin
            cmd.dec_rec = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/lrrb_dp.sv
`default_nettype none
`include "assert_macros.svh"
module lrrb_dp (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  [7:0]                  in_rx_byte,
  input  wire  [lrrb_pkg::SIZE_W-1:0] in_request_size,
  input  wire                         out_stall,
  output logic                        out_valid,
  output logic [7:0]                  out_data_byte,
  output logic                        out_has_data,
  output logic                        out_last,
  output logic                        out_refused,
  output logic [lrrb_pkg::LEN_W-1:0]  out_line_length,
  input  wire lrrb_pkg::lrrb_cmd_t    cmd,
  output lrrb_pkg::lrrb_sts_t         sts
);
  import lrrb_pkg::*;

  logic [7:0]       mem [BUF_DEPTH];
  logic [7:0]       mem_q_r;

  logic [IDX_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [REC_W-1:0] rec_r, rec_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             refuse_r;
  logic             out_valid_r;

  logic             mem_we;
  logic [7:0]       mem_wd;
  logic [IDX_W-1:0] wr_adv, rd_adv, wr_step;
  logic [LEN_W-1:0] len_inc;
  logic             byte_nl;
  logic             load_any;

  assign wr_adv   = next_idx(wr_r);
  assign rd_adv   = next_idx(rd_r);
  assign byte_nl  = (mem_q_r == NEWLINE);
  assign wr_step  = (!byte_nl && ovf_r) ? wr_adv : wr_r;
  assign len_inc  = len_r + 1'b1;
  assign load_any = cmd.load_refused | cmd.load_empty | cmd.load_byte;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    rec_nxt = rec_r;
    ovf_nxt = ovf_r;
    len_nxt = len_r;
    mem_we  = 1'b0;
    mem_wd  = in_rx_byte;
    if (cmd.rx_write) begin
      mem_we = 1'b1;
      if (wr_adv != rd_r && !ovf_r) begin
        if (in_rx_byte == NEWLINE && rec_r != REC_MAX) rec_nxt = rec_r + 1'b1;
        wr_nxt = wr_adv;
      end else begin
        // full or overflowed: park a newline in the write slot, count it once
        mem_wd = NEWLINE;
        if (!ovf_r && rec_r != REC_MAX) rec_nxt = rec_r + 1'b1;
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.rd_start) len_nxt = '0;
    if (cmd.load_byte) begin
      rd_nxt  = rd_adv;
      len_nxt = len_inc;
      if (!byte_nl && ovf_r) begin
        ovf_nxt = 1'b0;
        wr_nxt  = wr_adv;
      end
    end
    if (cmd.dec_rec) rec_nxt = rec_r - 1'b1;
  end

  always_comb begin
    sts.refuse    = refuse_r;
    sts.empty     = (wr_r == rd_r);
    sts.byte_last = byte_nl || (rd_adv == wr_step) || (len_inc == LEN_W'(BUF_DEPTH));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // read address follows the index it will hold, so data lines up with the held index
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_r] <= mem_wd;
    mem_q_r <= mem[rd_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r        <= '0;
      rd_r        <= '0;
      rec_r       <= '0;
      ovf_r       <= 1'b0;
      refuse_r    <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      rec_r <= rec_nxt;
      ovf_r <= ovf_nxt;
      len_r <= len_nxt;
      if (cmd.rd_start) begin
        refuse_r <= (in_request_size > SIZE_W'(BUF_DEPTH)) || (rec_r == '0);
      end
      if (load_any) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_any) begin
      out_data_byte   <= cmd.load_byte ? mem_q_r : 8'h00;
      out_has_data    <= cmd.load_byte;
      out_last        <= !cmd.load_byte || sts.byte_last;
      out_refused     <= cmd.load_refused;
      out_line_length <= (cmd.load_byte && sts.byte_last) ? len_inc : '0;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_CLK(a_dec_nonzero, cmd.dec_rec |-> (rec_r != '0), "record count underflow")
  `ASSERT_CLK(a_load_free, load_any |-> sts.out_free, "result loaded over a waiting one")
  `ASSERT_CLK(a_one_load, $onehot0({cmd.load_refused, cmd.load_empty, cmd.load_byte}),
              "more than one result loaded in a cycle")

endmodule
`default_nettype wire

### rtl/line_record_rx_ring_buffer.sv
`default_nettype none
// Receive ring buffer of BUF_DEPTH bytes that counts newline-terminated
// records. A receive item (opcode 0) is taken back to back while no read
// runs and gives no result; once the ring fills, a newline is parked in
// the write slot, overflow latches and later bytes are dropped. A read
// item (opcode 1) gives one result when refused (size above BUF_DEPTH or
// no record) or when the ring is empty, else one result per byte up to
// and including the newline, the last held byte or BUF_DEPTH bytes, the
// last flagged with the line length. A read's accept edge registers the
// size check and the first memory read; a refused or empty result is
// loaded from the head-check state, the first byte from the data state
// after it, then one byte per cycle while the output is not stalled. The
// registered refusal flag and memory read and the head-check state set
// that order. No new item is taken until the read loads its final result.
module line_record_rx_ring_buffer (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         in_opcode,
  input  wire  [7:0]                  in_rx_byte,
  input  wire  [lrrb_pkg::SIZE_W-1:0] in_request_size,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [7:0]                  out_data_byte,
  output logic                        out_has_data,
  output logic                        out_last,
  output logic                        out_refused,
  output logic [lrrb_pkg::LEN_W-1:0]  out_line_length
);
  import lrrb_pkg::*;

  lrrb_cmd_t cmd;   // sequencing commands
  lrrb_sts_t sts;   // ring and output status

  // Controller: accepts items, sequences a read byte by byte.
  lrrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: byte memory, indexes, record count, overflow flag and the
  // output register that decouples the result side.
  lrrb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .in_request_size (in_request_size),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_data_byte   (out_data_byte),
    .out_has_data    (out_has_data),
    .out_last        (out_last),
    .out_refused     (out_refused),
    .out_line_length (out_line_length),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire

### verif/tb_line_record_rx_ring_buffer.sv
module tb_line_record_rx_ring_buffer;
  import lrrb_pkg::*;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0]       data;
    logic             has_data;
    logic             last;
    logic             refused;
    logic [LEN_W-1:0] len;
  } line_beat_t;

  // One row of the directed table. A pinned row carries its own expected
  // result; all others are checked against the ring mirror.
  typedef struct packed {
    logic              op;
    logic [7:0]        rx_byte;
    logic [SIZE_W-1:0] size;
    logic [7:0]        reps;
    logic              pinned;
    line_beat_t        beat;
  } stim_row_t;

  localparam int RAND_ITEMS = 20;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_opcode = OP_RX;
  logic [7:0]        in_rx_byte = 8'h00;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_data_byte;
  logic              out_has_data;
  logic              out_last;
  logic              out_refused;
  logic [LEN_W-1:0]  out_line_length;

  // Mirror of the ring: bytes, pointers, line count and overflow latch.
  logic [7:0]        ring_mem [BUF_DEPTH];
  logic [IDX_W-1:0]  wr_ptr = '0;
  logic [IDX_W-1:0]  rd_ptr = '0;
  logic [REC_W-1:0]  lines_held = '0;
  logic              ovf_latched = 1'b0;

  line_beat_t        mirror_beats [$];    // results of the item just taken
  line_beat_t        expected_beats [$];  // results still owed by the block
  stim_row_t         plan [$];

  logic              idle_en = 1'b0;      // gates gaps on both sides
  logic              last_rx_nl = 1'b0;
  int                items_sent = 0;
  int                mismatches = 0;
  int                stall_left = 0;

  line_record_rx_ring_buffer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_rx_byte      (in_rx_byte),
    .in_request_size (in_request_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_has_data    (out_has_data),
    .out_last        (out_last),
    .out_refused     (out_refused),
    .out_line_length (out_line_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every item gapped, every
  // read a full-depth line with every result stalled for a full burst).
  initial begin
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic line_beat_t beat(input logic [7:0] d, input logic h, input logic l,
                                      input logic r, input logic [LEN_W-1:0] n);
    line_beat_t b;
    b.data     = d;
    b.has_data = h;
    b.last     = l;
    b.refused  = r;
    b.len      = n;
    return b;
  endfunction

  function automatic stim_row_t row(input logic op, input logic [7:0] b,
                                    input logic [SIZE_W-1:0] size, input int reps,
                                    input logic pinned, input line_beat_t exp_beat);
    stim_row_t r;
    r.op      = op;
    r.rx_byte = b;
    r.size    = size;
    r.reps    = 8'(reps);
    r.pinned  = pinned;
    r.beat    = exp_beat;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] p);
    return IDX_W'((int'(p) + 1) % BUF_DEPTH);
  endfunction

  function automatic logic [7:0] any_byte_but_nl();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= NEWLINE) b = b + 8'd1;
    return b;
  endfunction

  // Advance the mirror by one accepted item; results land in mirror_beats.
  task automatic ring_mirror_step(input logic op, input logic [7:0] b,
                                  input logic [SIZE_W-1:0] size);
    logic [IDX_W-1:0] nxt;
    logic [7:0]       c;
    int               n;
    mirror_beats.delete();
    if (op == OP_RX) begin
      nxt = ring_advance(wr_ptr);
      if (nxt != rd_ptr && !ovf_latched) begin
        if (b == NEWLINE && lines_held != REC_MAX) lines_held = lines_held + 1'b1;
        ring_mem[wr_ptr] = b;
        wr_ptr = nxt;
      end else begin
        // full or already overflowed: park a newline, count only on entry
        ring_mem[wr_ptr] = NEWLINE;
        if (!ovf_latched && lines_held != REC_MAX) lines_held = lines_held + 1'b1;
        ovf_latched = 1'b1;
      end
    end else if (int'(size) > BUF_DEPTH || lines_held == '0) begin
      mirror_beats.push_back(beat(8'h00, 1'b0, 1'b1, 1'b1, '0));
    end else begin
      n = 0;
      while (wr_ptr != rd_ptr && n < BUF_DEPTH) begin
        c = ring_mem[rd_ptr];
        mirror_beats.push_back(beat(c, 1'b1, 1'b0, 1'b0, '0));
        n++;
        rd_ptr = ring_advance(rd_ptr);
        if (c == NEWLINE) break;
        if (ovf_latched) begin
          // first data byte out frees the parked newline
          ovf_latched = 1'b0;
          wr_ptr = ring_advance(wr_ptr);
        end
      end
      lines_held = lines_held - 1'b1;
      if (n == 0) begin
        mirror_beats.push_back(beat(8'h00, 1'b0, 1'b1, 1'b0, '0));
      end else begin
        mirror_beats[n-1].last = 1'b1;
        mirror_beats[n-1].len  = LEN_W'(n);
      end
    end
  endtask

  // Hand one item to the block, maybe after an idle burst, and book its
  // results once the handshake completes.
  task automatic push_item(input logic op, input logic [7:0] b, input logic [SIZE_W-1:0] size,
                           input logic pinned, input line_beat_t pin_beat);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_rx_byte      <= b;
    in_request_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ring_mirror_step(op, b, size);
    if (pinned) begin
      expected_beats.push_back(pin_beat);
    end else begin
      foreach (mirror_beats[k]) expected_beats.push_back(mirror_beats[k]);
    end
    if (op == OP_RX) last_rx_nl = (b == NEWLINE);
    items_sent++;
  endtask

  task automatic push_rx(input logic [7:0] b);
    push_item(OP_RX, b, SIZE_W'($urandom_range(0, 65535)), 1'b0, '0);
  endtask

  task automatic push_read(input logic [SIZE_W-1:0] size);
    push_item(OP_READ, 8'($urandom_range(0, 255)), size, 1'b0, '0);
  endtask

  // A line of random non-newline bytes and its terminator. Never two
  // newlines in a row, so random traffic cannot fill the ring with bare
  // newlines and wedge it in overflow.
  task automatic push_line(input int n);
    int k;
    if (n == 0 && last_rx_nl) n = 1;
    for (k = 0; k < n; k++) push_rx(any_byte_but_nl());
    push_rx(NEWLINE);
  endtask

  task automatic note_mismatch(input line_beat_t want, input line_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: exp data=%02h has=%0b last=%0b ref=%0b len=%0d",
               $realtime, want.data, want.has_data, want.last, want.refused, want.len);
      $display("                 got data=%02h has=%0b last=%0b ref=%0b len=%0d",
               got.data, got.has_data, got.last, got.refused, got.len);
    end
  endtask

  // Result side: random stall bursts, started only while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every accepted result item is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    line_beat_t got;
    line_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = beat(out_data_byte, out_has_data, out_last, out_refused, out_line_length);
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item at %0t: data=%02h has=%0b last=%0b ref=%0b len=%0d",
                   $realtime, got.data, got.has_data, got.last, got.refused, got.len);
      end else begin
        want = expected_beats.pop_front();
        if (got.data !== want.data || got.has_data !== want.has_data ||
            got.last !== want.last || got.refused !== want.refused ||
            got.len !== want.len)
          note_mismatch(want, got);
      end
    end
  end

  initial begin : stimulus
    line_beat_t refusal;
    stim_row_t  r;
    int         start;
    int         pick;
    int         k;

    refusal = beat(8'h00, 1'b0, 1'b1, 1'b1, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: op, byte, size, repeat, pinned, expected item.
    plan.push_back(row(OP_READ, 8'h00, 16'd0,     1, 1'b1, refusal)); // nothing held after reset
    plan.push_back(row(OP_READ, 8'h00, 16'd65,    1, 1'b1, refusal)); // size just above depth
    plan.push_back(row(OP_RX,   8'h68, 16'd0,     1, 1'b0, '0));
    plan.push_back(row(OP_RX,   8'h69, 16'd0,     1, 1'b0, '0));
    plan.push_back(row(OP_RX,   NEWLINE, 16'd0,   1, 1'b0, '0));
    plan.push_back(row(OP_READ, 8'h00, 16'hFFFF,  1, 1'b1, refusal)); // largest size, line waiting
    plan.push_back(row(OP_READ, 8'h00, 16'd64,    1, 1'b0, '0));      // size equal to depth
    plan.push_back(row(OP_RX,   NEWLINE, 16'd0,   1, 1'b0, '0));
    plan.push_back(row(OP_READ, 8'h00, 16'd0,     1, 1'b0, '0));      // bare newline line
    plan.push_back(row(OP_RX,   8'h00, 16'd0,     1, 1'b0, '0));
    plan.push_back(row(OP_RX,   8'hFF, 16'd0,     1, 1'b0, '0));
    plan.push_back(row(OP_RX,   NEWLINE, 16'd0,   1, 1'b0, '0));
    plan.push_back(row(OP_READ, 8'h00, 16'd1,     1, 1'b0, '0));
    plan.push_back(row(OP_RX,   8'h41, 16'd0,    66, 1'b0, '0));      // fill, wrap, overflow, drops
    plan.push_back(row(OP_READ, 8'h00, 16'd32,    1, 1'b0, '0));      // full-depth line
    plan.push_back(row(OP_READ, 8'h00, 16'd10,    1, 1'b1, refusal)); // drained
    plan.push_back(row(OP_RX,   8'h78, 16'd0,     1, 1'b0, '0));
    plan.push_back(row(OP_READ, 8'h00, 16'd5,     1, 1'b1, refusal)); // byte held, no newline yet
    plan.push_back(row(OP_RX,   NEWLINE, 16'd0,   1, 1'b0, '0));
    plan.push_back(row(OP_READ, 8'h00, 16'd63,    1, 1'b0, '0));

    idle_en <= 1'b1;
    foreach (plan[i]) begin
      r = plan[i];
      for (k = 0; k < int'(r.reps); k++) push_item(r.op, r.rx_byte, r.size, r.pinned, r.beat);
    end

    // Random traffic: mostly short lines and legal reads, some oversize
    // reads, and now and then a long run that pushes the ring into overflow.
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      if ($urandom_range(0, 19) == 0) idle_en <= !idle_en;
      pick = $urandom_range(0, 99);
      if (pick < 55)      push_line($urandom_range(0, 12));
      else if (pick < 62) push_line($urandom_range(50, 80));
      else if (pick < 90) push_read(SIZE_W'($urandom_range(0, BUF_DEPTH)));
      else                push_read(SIZE_W'($urandom_range(BUF_DEPTH + 1, 65535)));
    end

    // Closing stretch, no idling. Drain to an empty ring, then fill it with
    // bare newlines so overflow latches with nothing to clear it: reads walk
    // the newlines, the last counted line finds the ring empty, and the
    // one after that is refused.
    idle_en <= 1'b0;
    for (k = 0; k < 400 && (lines_held != '0 || rd_ptr != wr_ptr || ovf_latched); k++) begin
      if (lines_held == '0) push_rx(NEWLINE);
      else push_read(SIZE_W'($urandom_range(0, BUF_DEPTH)));
    end
    for (k = 0; k < BUF_DEPTH; k++) push_rx(NEWLINE);
    push_rx(any_byte_but_nl());
    for (k = 0; k < BUF_DEPTH + 1; k++) push_read(SIZE_W'($urandom_range(0, BUF_DEPTH)));

    in_valid <= 1'b0;
    for (k = 0; k < 20000 && expected_beats.size() != 0; k++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0d result items never arrived", expected_beats.size());
      mismatches += expected_beats.size();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/lrrb_pkg.sv
rtl/lrrb_ctrl.sv
rtl/lrrb_dp.sv
rtl/line_record_rx_ring_buffer.sv
verif/tb_line_record_rx_ring_buffer.sv
